// ===== hdl/u8enc_pkg.sv =====
package u8enc_pkg;

   // Width of the byte limit register and of the running byte count.
   localparam int LIMIT_BITS = 16;
   localparam int COUNT_BITS = LIMIT_BITS + 1;

   // Field widths.
   localparam int CP_BITS    = 31;
   localparam int LEN_BITS   = 3;
   localparam int CHUNK_BITS = 6;
   localparam int CHUNKS     = 6;
   localparam int WIDE_BITS  = CHUNK_BITS * CHUNKS;

   // Configuration port.
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = LIMIT_BITS;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_LIMIT_ENABLE = 1'b0,
      CSR_BYTE_LIMIT   = 1'b1
   } u8enc_csr_type;

   // Sequencer states.
   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } u8enc_state_type;

   // Encoded length thresholds.
   localparam logic [CP_BITS-1:0] LEN2_MIN = 31'h0000_0080;
   localparam logic [CP_BITS-1:0] LEN3_MIN = 31'h0000_0800;
   localparam logic [CP_BITS-1:0] LEN4_MIN = 31'h0001_0000;
   localparam logic [CP_BITS-1:0] LEN4_MAX = 31'h001F_FFFF;
   localparam logic [CP_BITS-1:0] LEN5_MAX = 31'h03FF_FFFF;

   // Byte prefixes.
   localparam logic [7:0] CONT_PREFIX = 8'h80;

   // Number of bytes in the encoding of a code point.
   function automatic logic [LEN_BITS-1:0] enc_length(input logic [CP_BITS-1:0] cp);
      logic [LEN_BITS-1:0] len;
      if (cp < LEN2_MIN) begin
         len = 3'd1;
      end else if (cp < LEN3_MIN) begin
         len = 3'd2;
      end else if (cp < LEN4_MIN) begin
         len = 3'd3;
      end else if (cp <= LEN4_MAX) begin
         len = 3'd4;
      end else if (cp <= LEN5_MAX) begin
         len = 3'd5;
      end else begin
         len = 3'd6;
      end
      return len;
   endfunction

   // Lead byte prefix for a multi-byte encoding.
   function automatic logic [7:0] lead_prefix(input logic [LEN_BITS-1:0] len);
      logic [7:0] prefix;
      case (len)
         3'd2:    prefix = 8'hC0;
         3'd3:    prefix = 8'hE0;
         3'd4:    prefix = 8'hF0;
         3'd5:    prefix = 8'hF8;
         3'd6:    prefix = 8'hFC;
         default: prefix = 8'h00;
      endcase
      return prefix;
   endfunction

endpackage

// ===== hdl/u8enc_req_if.sv =====
interface u8enc_req_if
   import u8enc_pkg::*;
;
   logic               valid;
   logic               ready;
   logic [CP_BITS-1:0] code_point;
   logic               string_start;

   modport source (output valid, output code_point, output string_start, input ready);
   modport sink   (input valid, input code_point, input string_start, output ready);
endinterface

// ===== hdl/u8enc_rsp_if.sv =====
interface u8enc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_byte;

   modport source (output valid, output out_byte, output last_byte, input ready);
   modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

// ===== hdl/utf8_encoder_with_byte_limit.sv =====
// UTF-8 encoder in the original 1-to-6-byte form with a per-string byte limit. Each item on
// req_ch carries a 31-bit code point and a string_start flag; the encoding leaves on rsp_ch one
// byte per item, lead byte first, with last_byte set on the final byte. A running byte count,
// cleared by string_start, adds every character's length (saturating at 17 bits), and when
// limit_enable is set and byte_limit is nonzero a character that pushes the count past the limit
// gives no bytes. The block accepts a character, updates the count and judges the limit, then
// delivers its bytes as rsp_ch takes them while a down counter steps a shared 6-bit chunk
// selector through the code point; a suppressed character leaves the block idle.
// req_ch.ready is high only between characters. Registers are to be written by the user through
// csr_we, csr_index and csr_wdata only while the block is idle; the block does not enforce this.
module utf8_encoder_with_byte_limit
   import u8enc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   u8enc_req_if.sink                 req_ch,
   u8enc_rsp_if.source               rsp_ch,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   u8enc_state_type        state_ff, state_in;
   logic                   limit_en_ff, limit_en_in;
   logic [LIMIT_BITS-1:0]  limit_ff, limit_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [CP_BITS-1:0]     cp_ff, cp_in;
   logic [LEN_BITS-1:0]    len_ff, len_in;
   logic [LEN_BITS-1:0]    idx_ff, idx_in;
   logic                   lead_ff, lead_in;

   logic                   req_fire;
   logic                   rsp_fire;
   logic [LEN_BITS-1:0]    new_len;
   logic [COUNT_BITS-1:0]  count_base;
   logic [COUNT_BITS:0]    count_sum;
   logic [COUNT_BITS-1:0]  count_sat;
   logic                   emit;
   logic [WIDE_BITS-1:0]   cp_wide;
   logic [CHUNK_BITS-1:0]  chunk;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_fire = rsp_ch.valid && rsp_ch.ready;

   // Configuration registers.
   always_comb begin
      limit_en_in = limit_en_ff;
      limit_in    = limit_ff;
      if (csr_we) begin
         case (u8enc_csr_type'(csr_index))
            CSR_LIMIT_ENABLE: limit_en_in = csr_wdata[0];
            CSR_BYTE_LIMIT:   limit_in    = csr_wdata[LIMIT_BITS-1:0];
            default:          limit_en_in = limit_en_ff;
         endcase
      end
   end

   // Length, running count and limit check for the incoming character.
   always_comb begin
      new_len    = enc_length(req_ch.code_point);
      count_base = req_ch.string_start ? '0 : count_ff;
      count_sum  = {1'b0, count_base} + {{(COUNT_BITS+1-LEN_BITS){1'b0}}, new_len};
      count_sat  = count_sum[COUNT_BITS] ? '1 : count_sum[COUNT_BITS-1:0];
      emit       = !limit_en_ff || (limit_ff == '0) || (count_sat <= {1'b0, limit_ff});
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && emit) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_fire && (idx_ff == '0)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath registers: capture on accept, step the chunk index per delivered byte.
   always_comb begin
      count_in = count_ff;
      cp_in    = cp_ff;
      len_in   = len_ff;
      idx_in   = idx_ff;
      lead_in  = lead_ff;
      if (req_fire) begin
         count_in = count_sat;
         cp_in    = req_ch.code_point;
         len_in   = new_len;
         idx_in   = new_len - 3'd1;
         lead_in  = 1'b1;
      end else if (rsp_fire) begin
         idx_in  = idx_ff - 3'd1;
         lead_in = 1'b0;
      end
   end

   // Shared chunk selector: picks the 6-bit group named by the down counter.
   always_comb begin
      cp_wide = {{(WIDE_BITS-CP_BITS){1'b0}}, cp_ff};
      case (idx_ff)
         3'd0:    chunk = cp_wide[5:0];
         3'd1:    chunk = cp_wide[11:6];
         3'd2:    chunk = cp_wide[17:12];
         3'd3:    chunk = cp_wide[23:18];
         3'd4:    chunk = cp_wide[29:24];
         3'd5:    chunk = cp_wide[35:30];
         default: chunk = '0;
      endcase
   end

   // Outputs.
   always_comb begin
      req_ch.ready     = (state_ff == ST_IDLE);
      rsp_ch.valid     = (state_ff == ST_EMIT);
      rsp_ch.last_byte = (idx_ff == '0);
      if (lead_ff && (len_ff == 3'd1)) begin
         rsp_ch.out_byte = {1'b0, cp_ff[6:0]};
      end else if (lead_ff) begin
         rsp_ch.out_byte = lead_prefix(len_ff) | {2'b00, chunk};
      end else begin
         rsp_ch.out_byte = CONT_PREFIX | {2'b00, chunk};
      end
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         limit_en_ff <= 1'b0;
         limit_ff    <= '0;
         count_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         limit_en_ff <= limit_en_in;
         limit_ff    <= limit_in;
         count_ff    <= count_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cp_ff   <= cp_in;
      len_ff  <= len_in;
      idx_ff  <= idx_in;
      lead_ff <= lead_in;
   end

endmodule

// ===== hdl/u8enc_checker.sv =====
module u8enc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_byte
);

   // A stalled byte holds its value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last_byte)))
   else $error("stalled output byte changed");

   // The block takes no new character while bytes are pending.
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
   else $error("input ready while output pending");

   // After the final byte of a character the block is ready again.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_byte) |=> (req_ready && !rsp_valid))
   else $error("not ready after final byte");

   // A byte that is not the last is followed by another byte.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_byte) |=> rsp_valid)
   else $error("character ended without a final byte");

endmodule

bind utf8_encoder_with_byte_limit u8enc_checker u_u8enc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_out_byte  (rsp_ch.out_byte),
   .rsp_last_byte (rsp_ch.last_byte)
);

// ===== dv/utf8_encoder_with_byte_limit_test.sv =====
`timescale 1ns / 100ps

module utf8_encoder_with_byte_limit_test;
   import u8enc_pkg::*;

   // Byte prefixes of the encoding.
   localparam logic [7:0] LEAD_2 = 8'hC0;
   localparam logic [7:0] LEAD_3 = 8'hE0;
   localparam logic [7:0] LEAD_4 = 8'hF0;
   localparam logic [7:0] LEAD_5 = 8'hF8;
   localparam logic [7:0] LEAD_6 = 8'hFC;
   localparam logic [7:0] CONT_MARK = 8'h80;

   localparam int unsigned COUNT_LIMIT = (1 << COUNT_BITS) - 1;
   localparam int SETTLE_CYCLES = 6;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 60;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } coded_byte_type;

   logic clock;
   logic reset;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   u8enc_req_if req_ch ();
   u8enc_rsp_if rsp_ch ();

   utf8_encoder_with_byte_limit dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor state: running string total and the register copies.
   logic [COUNT_BITS-1:0] string_bytes = '0;
   logic                  limit_on = 1'b0;
   logic [LIMIT_BITS-1:0] byte_cap = '0;

   coded_byte_type pending_bytes[$];
   int  error_count = 0;
   bit  stalls_on = 1'b0;
   bit  long_hold_request = 1'b0;

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Generous limit on the whole run.
   initial begin
      #10_000_000;
      $display("FAIL utf8_encoder_with_byte_limit");
      $finish;
   end

   // Random gap length: mostly short, a few long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) begin
         return $urandom_range(1, 3);
      end else if (r < 95) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // Random code point, usually drawn from one encoded-length class.
   function automatic logic [CP_BITS-1:0] pick_code_point();
      case ($urandom_range(1, 7))
         1: return CP_BITS'($urandom_range(0, 32'h7F));
         2: return CP_BITS'($urandom_range(32'h80, 32'h7FF));
         3: return CP_BITS'($urandom_range(32'h800, 32'hFFFF));
         4: return CP_BITS'($urandom_range(32'h1_0000, 32'h1F_FFFF));
         5: return CP_BITS'($urandom_range(32'h20_0000, 32'h3FF_FFFF));
         6: return CP_BITS'($urandom_range(32'h400_0000, 32'h7FFF_FFFF));
         default: return CP_BITS'($urandom());
      endcase
   endfunction

   // Update the string total for one character and queue the bytes it should give.
   function automatic void predict_char(input logic [CP_BITS-1:0] cp, input logic start);
      int unsigned len;
      int unsigned total;
      logic [CP_BITS-1:0] shifted;
      logic [7:0] lead;
      coded_byte_type item;
      if (cp < LEN2_MIN) begin
         len = 1;
         lead = 8'h00;
      end else if (cp < LEN3_MIN) begin
         len = 2;
         lead = LEAD_2;
      end else if (cp < LEN4_MIN) begin
         len = 3;
         lead = LEAD_3;
      end else if (cp <= LEN4_MAX) begin
         len = 4;
         lead = LEAD_4;
      end else if (cp <= LEN5_MAX) begin
         len = 5;
         lead = LEAD_5;
      end else begin
         len = 6;
         lead = LEAD_6;
      end
      if (start) begin
         string_bytes = '0;
      end
      // The total saturates rather than wrapping.
      total = int'(string_bytes) + len;
      if (total > COUNT_LIMIT) begin
         total = COUNT_LIMIT;
      end
      string_bytes = total[COUNT_BITS-1:0];
      if (limit_on && byte_cap != 0 && string_bytes > byte_cap) begin
         return;
      end
      for (int k = 0; k < len; k++) begin
         shifted = cp >> (6 * (len - 1 - k));
         if (k == 0) begin
            item.out_byte = (len == 1) ? cp[7:0] : (lead | shifted[7:0]);
         end else begin
            item.out_byte = CONT_MARK | {2'b00, shifted[5:0]};
         end
         item.last_byte = (k == len - 1);
         pending_bytes.push_back(item);
      end
   endfunction

   // Offer one character and wait until the block takes it.
   task automatic send_char(input logic [CP_BITS-1:0] cp, input logic start);
      int gap;
      gap = (stalls_on && $urandom_range(0, 1) == 0) ? pick_gap() : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.code_point   <= cp;
      req_ch.string_start <= start;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_char(cp, start);
   endtask

   // Stop offering items and wait until every expected byte has come out.
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both registers while the block is idle.
   task automatic apply_limits(input logic [CSR_DATA_BITS-1:0] enable_word,
                               input logic [CSR_DATA_BITS-1:0] limit);
      settle();
      csr_we    <= 1'b1;
      csr_index <= CSR_LIMIT_ENABLE;
      csr_wdata <= enable_word;
      @(posedge clock);
      csr_index <= CSR_BYTE_LIMIT;
      csr_wdata <= limit;
      @(posedge clock);
      csr_we <= 1'b0;
      limit_on = enable_word[0];
      byte_cap = limit;
      @(posedge clock);
   endtask

   // Every encoded-length boundary and both extremes, with the limit off after reset.
   task automatic test_code_point_lengths();
      send_char(31'h0000_0000, 1'b1);
      send_char(31'h0000_007F, 1'b0);
      send_char(31'h0000_0080, 1'b0);
      send_char(31'h0000_07FF, 1'b0);
      send_char(31'h0000_0800, 1'b0);
      send_char(31'h0000_FFFF, 1'b0);
      send_char(31'h0001_0000, 1'b0);
      send_char(31'h001F_FFFF, 1'b0);
      send_char(31'h0020_0000, 1'b0);
      send_char(31'h03FF_FFFF, 1'b0);
      send_char(31'h0400_0000, 1'b1);
      send_char(31'h5555_5555, 1'b0);
      send_char(31'h2AAA_AAAA, 1'b0);
      send_char(31'h7FFF_FFFF, 1'b0);
   endtask

   // Suppression inside a string, a new string, the limit turned off and a zero limit.
   task automatic test_byte_limit();
      apply_limits(16'h0001, 16'd5);
      send_char(31'h41, 1'b1);
      send_char(31'h3A9, 1'b0);
      send_char(31'h7FF, 1'b0);
      send_char(31'h42, 1'b0);
      send_char(31'h43, 1'b0);
      send_char(31'h44, 1'b1);
      apply_limits(16'hFFFE, 16'd5);
      send_char(31'h20AC, 1'b0);
      apply_limits(16'h0001, 16'd0);
      send_char(31'h1_F600, 1'b0);
      apply_limits(16'h0001, 16'd5);
      send_char(31'h45, 1'b0);
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering items.
   task automatic test_output_backpressure();
      apply_limits(16'h0000, 16'hFFFF);
      long_hold_request = 1'b1;
      send_char(31'h7FFF_FFFF, 1'b1);
      for (int i = 0; i < 8; i++) begin
         send_char(pick_code_point(), 1'b0);
      end
      settle();
   endtask

   // Random strings under several register settings, with some loose items mixed in.
   task automatic test_random_strings();
      int sent;
      int str_len;
      logic [CSR_DATA_BITS-1:0] enable_word;
      logic [CSR_DATA_BITS-1:0] limit;
      for (int phase = 0; phase < 6; phase++) begin
         enable_word = CSR_DATA_BITS'($urandom_range(0, 16'hFFFF)) | 16'h0001;
         case (phase)
            0: begin
               enable_word = enable_word & 16'hFFFE;
               limit = CSR_DATA_BITS'($urandom_range(0, 16'hFFFF));
            end
            1: limit = '0;
            2: limit = CSR_DATA_BITS'($urandom_range(1, 30));
            3: limit = 16'hFFFF;
            4: limit = 16'd1;
            default: limit = CSR_DATA_BITS'($urandom_range(1, 16'hFFFF));
         endcase
         apply_limits(enable_word, limit);
         // One phase runs without any idling on either side.
         stalls_on = (phase != 3);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < 85) begin
               str_len = $urandom_range(1, 10);
               for (int i = 0; i < str_len; i++) begin
                  send_char(pick_code_point(), i == 0);
               end
               sent += str_len;
            end else begin
               send_char(CP_BITS'($urandom()), 1'($urandom_range(0, 1)));
               sent++;
            end
         end
      end
      stalls_on = 1'b0;
   endtask

   // Output ready: random holds, plus one long hold on request.
   initial begin : drive_rsp_ready
      int wait_left;
      wait_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            wait_left = LONG_HOLD_CYCLES;
         end else if (wait_left == 0 && stalls_on && $urandom_range(0, 2) == 0) begin
            wait_left = pick_gap();
         end
         if (wait_left > 0) begin
            rsp_ch.ready <= 1'b0;
            wait_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Compare each byte taken from the block with the oldest expected one.
   always @(posedge clock) begin : check_bytes
      coded_byte_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_bytes.size() == 0) begin
            $error("unexpected item: out_byte %h last_byte %b",
                   rsp_ch.out_byte, rsp_ch.last_byte);
            error_count++;
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_ch.out_byte !== want.out_byte) begin
               $error("out_byte: expected %h, got %h", want.out_byte, rsp_ch.out_byte);
               error_count++;
            end
            if (rsp_ch.last_byte !== want.last_byte) begin
               $error("last_byte: expected %b, got %b", want.last_byte, rsp_ch.last_byte);
               error_count++;
            end
         end
      end
   end

   // Test sequence.
   initial begin
      req_ch.valid        <= 1'b0;
      req_ch.code_point   <= '0;
      req_ch.string_start <= 1'b0;
      csr_we    <= 1'b0;
      csr_index <= CSR_LIMIT_ENABLE;
      csr_wdata <= '0;
      reset     <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_code_point_lengths();
      test_byte_limit();
      test_output_backpressure();
      test_random_strings();
      settle();

      if (error_count == 0) begin
         $display("PASS utf8_encoder_with_byte_limit");
      end else begin
         $display("FAIL utf8_encoder_with_byte_limit");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/u8enc_pkg.sv
hdl/u8enc_req_if.sv
hdl/u8enc_rsp_if.sv
hdl/utf8_encoder_with_byte_limit.sv
hdl/u8enc_checker.sv
dv/utf8_encoder_with_byte_limit_test.sv
